[src/mbx_pkg.sv]
// shared types, constants and helpers for the mailbox ring deque
`default_nettype none

package mbx_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned IDX_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned MSG_W  = 32;
   localparam int unsigned CAP_W  = 5;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

   // register index, taken from the word address bit
   localparam logic CAPACITY_IDX = 1'b0;

   localparam logic [KIND_W-1:0] KIND_GET       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POST_TAIL = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POST_HEAD = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [MSG_W-1:0]  message;
      logic              waiter_present;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [MSG_W-1:0]  message_out;
      logic              to_waiter;
   } rsp_type;

   // slots in use: zero counts as one, anything above the depth saturates
   function automatic logic [CNT_W-1:0] mbx_cap_eff(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] result;
      if (cap == '0) begin
         result = CNT_W'(1);
      end else if (CNT_W'(cap) > CNT_W'(DEPTH)) begin
         result = CNT_W'(DEPTH);
      end else begin
         result = CNT_W'(cap);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[src/mbx_slot_ram.sv]
// message slot memory, one write port and one registered read port
`default_nettype none

module mbx_slot_ram
   import mbx_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [MSG_W-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      logic [MSG_W-1:0] rd_data
);

   logic [MSG_W-1:0] mem [DEPTH];
   logic [MSG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/mailbox_ring_deque.sv]
// top level of the mailbox ring deque: control, pointers, registers and result beat
// A post beat (tail, urgent head, or handed to a waiting task) and a get beat on an
// empty mailbox load their result register directly; a get that finds a message
// reads its slot into the memory's read register, and the read state then loads
// that data into the result register. A new request beat is taken while the
// previous result beat is still waiting, as long as that result is not stalled.
// Writing the capacity register clears the pointers and the fill count; the slot
// memory needs no clearing pass, as a slot is only read after it has been written.
`default_nettype none

module mailbox_ring_deque
   import mbx_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire req_type           req_payload,
   output      logic              rsp_valid,
   input  wire logic              rsp_stall,
   output      rsp_type           rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output      logic [DATA_W-1:0] prdata,
   output      logic              pready
);

   state_type         state_ff, state_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [IDX_W-1:0]  read_index_ff, read_index_in;
   logic [IDX_W-1:0]  write_index_ff, write_index_in;
   logic [CNT_W-1:0]  fill_count_ff, fill_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic              req_accept;
   logic              cfg_sel;
   logic              cfg_write;
   logic [CNT_W-1:0]  cap_eff;
   logic [CNT_W-1:0]  cap_m1;
   logic [CNT_W-1:0]  ri_wide;
   logic [CNT_W-1:0]  ri_inc;
   logic [IDX_W-1:0]  tail_slot;
   logic [CNT_W-1:0]  tail_inc;
   logic              get_hit;
   rsp_type           rsp_now;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic              ram_re;
   logic [MSG_W-1:0]  ram_rdata;

   assign pready    = 1'b1;
   assign cfg_sel   = (paddr[ADDR_W-1:2] == CAPACITY_IDX);
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = cfg_sel ? DATA_W'(capacity_ff) : '0;

   assign req_accept = req_valid && !req_stall;

   assign cap_eff   = mbx_cap_eff(capacity_ff);
   assign cap_m1    = cap_eff - CNT_W'(1);
   assign ri_wide   = {1'b0, read_index_ff};
   assign ri_inc    = ri_wide + CNT_W'(1);
   assign tail_slot = ({1'b0, write_index_ff} >= cap_eff) ? '0 : write_index_ff;
   assign tail_inc  = {1'b0, tail_slot} + CNT_W'(1);

   // pointer, count and memory control
   always_comb begin
      capacity_in    = capacity_ff;
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      fill_count_in  = fill_count_ff;
      ram_we         = 1'b0;
      ram_waddr      = tail_slot;
      ram_re         = 1'b0;
      get_hit        = 1'b0;
      rsp_now        = '{status: STATUS_OK, message_out: '0, to_waiter: 1'b0};
      priority if (cfg_write && cfg_sel) begin
         capacity_in    = pwdata[CAP_W-1:0];
         read_index_in  = '0;
         write_index_in = '0;
         fill_count_in  = '0;
      end else if (req_accept) begin
         priority if (req_payload.kind == KIND_GET) begin
            if (fill_count_ff != '0) begin
               get_hit       = 1'b1;
               ram_re        = 1'b1;
               fill_count_in = fill_count_ff - CNT_W'(1);
               read_index_in = (ri_inc >= cap_eff) ? '0 : ri_inc[IDX_W-1:0];
            end else begin
               rsp_now.status = STATUS_EMPTY;
            end
         end else if (req_payload.waiter_present) begin
            rsp_now.message_out = req_payload.message;
            rsp_now.to_waiter   = 1'b1;
         end else if (fill_count_ff >= cap_eff) begin
            rsp_now.status = STATUS_FULL;
         end else if (req_payload.kind == KIND_POST_TAIL) begin
            ram_we         = 1'b1;
            ram_waddr      = tail_slot;
            fill_count_in  = fill_count_ff + CNT_W'(1);
            write_index_in = (tail_inc >= cap_eff) ? '0 : tail_inc[IDX_W-1:0];
         end else begin
            // urgent post, and the unused kind code, go in just before the head
            if (read_index_ff == '0 || ri_wide >= cap_eff) begin
               read_index_in = cap_m1[IDX_W-1:0];
            end else begin
               read_index_in = read_index_ff - IDX_W'(1);
            end
            ram_we        = 1'b1;
            ram_waddr     = read_index_in;
            fill_count_in = fill_count_ff + CNT_W'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (get_hit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs: request stall and the result register
   always_comb begin
      req_stall      = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_READ: begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = '{status: STATUS_OK, message_out: ram_rdata, to_waiter: 1'b0};
         end
         ST_IDLE: begin
            if (req_accept && !get_hit) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = rsp_now;
            end else if (rsp_valid_ff && !rsp_stall) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         capacity_ff    <= CAP_RESET;
         read_index_ff  <= '0;
         write_index_ff <= '0;
         fill_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         capacity_ff    <= capacity_in;
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         fill_count_ff  <= fill_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   mbx_slot_ram u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_payload.message),
      .rd_en   (ram_re),
      .rd_addr (read_index_ff),
      .rd_data (ram_rdata)
   );

   // a get that reads the memory always leaves the result register free for its data
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("result register busy while slot read completes");

   a_read_follows_get: assert property (@(posedge clock) disable iff (reset)
      get_hit |=> state_ff == ST_READ)
      else $error("slot read not followed by read state");

   a_no_take_during_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !req_accept && !ram_we && !ram_re)
      else $error("beat taken or memory accessed during slot read");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= cap_eff)
      else $error("fill count above slots in use");

   a_read_delivers: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> rsp_valid_ff && rsp_payload_ff.status == STATUS_OK)
      else $error("slot read did not produce a result beat");

endmodule

`default_nettype wire

[tb/mailbox_ring_deque_checker.sv]
// mailbox ring deque checker: watches the channels, predicts each result beat and compares
module mailbox_ring_deque_checker
   import mbx_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire req_type           req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rsp_type           rsp_payload,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic              pready,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output      int                failures,
   output      int                outstanding
);

   logic [MSG_W-1:0] slot_mem [DEPTH];
   logic [IDX_W-1:0] rd_ptr;
   logic [IDX_W-1:0] wr_ptr;
   logic [CNT_W-1:0] held;
   logic [CAP_W-1:0] capacity_reg;
   rsp_type          pending_replies [$];
   int               failure_total = 0;

   assign failures = failure_total;

   function automatic int unsigned slots_in_use(input logic [CAP_W-1:0] cap_value);
      if (cap_value == '0) begin
         return 1;
      end
      if (cap_value > CAP_W'(DEPTH)) begin
         return DEPTH;
      end
      return cap_value;
   endfunction

   // advances the mailbox copy by one request and returns the reply it should give
   function automatic rsp_type predict_mailbox_op(input req_type op);
      rsp_type     reply;
      int unsigned cap;
      int unsigned next_idx;
      reply.status      = STATUS_OK;
      reply.message_out = '0;
      reply.to_waiter   = 1'b0;
      cap = slots_in_use(capacity_reg);
      if (op.kind == KIND_GET) begin
         if (held != '0) begin
            held = held - 1'b1;
            reply.message_out = slot_mem[rd_ptr];
            next_idx = rd_ptr + 1;
            rd_ptr = (next_idx >= cap) ? '0 : IDX_W'(next_idx);
         end else begin
            reply.status = STATUS_EMPTY;
         end
      end else if (op.waiter_present) begin
         reply.message_out = op.message;
         reply.to_waiter   = 1'b1;
      end else if (held >= cap) begin
         reply.status = STATUS_FULL;
      end else if (op.kind == KIND_POST_TAIL) begin
         if (wr_ptr >= cap) begin
            wr_ptr = '0;
         end
         slot_mem[wr_ptr] = op.message;
         next_idx = wr_ptr + 1;
         wr_ptr = (next_idx >= cap) ? '0 : IDX_W'(next_idx);
         held = held + 1'b1;
      end else begin
         // urgent post, and the spare kind code behaves the same
         if (rd_ptr == '0 || rd_ptr >= cap) begin
            rd_ptr = IDX_W'(cap - 1);
         end else begin
            rd_ptr = rd_ptr - 1'b1;
         end
         slot_mem[rd_ptr] = op.message;
         held = held + 1'b1;
      end
      return reply;
   endfunction

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      failure_total++;
      if (failure_total <= 10) begin
         $write("mismatch (%s): expected status %0d message %h to_waiter %0b, ",
                what, want.status, want.message_out, want.to_waiter);
         $display("got status %0d message %h to_waiter %0b",
                  got.status, got.message_out, got.to_waiter);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         capacity_reg = CAP_RESET;
         rd_ptr       = '0;
         wr_ptr       = '0;
         held         = '0;
         pending_replies.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == CAPACITY_IDX) begin
            capacity_reg = pwdata[CAP_W-1:0];
            rd_ptr       = '0;
            wr_ptr       = '0;
            held         = '0;
         end
         if (req_valid && !req_stall) begin
            pending_replies.push_back(predict_mailbox_op(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               note_mismatch("beat with nothing expected", '0, rsp_payload);
            end else begin
               want = pending_replies.pop_front();
               if (want.status != rsp_payload.status) begin
                  note_mismatch("status", want, rsp_payload);
               end
               if (want.message_out != rsp_payload.message_out) begin
                  note_mismatch("message_out", want, rsp_payload);
               end
               if (want.to_waiter != rsp_payload.to_waiter) begin
                  note_mismatch("to_waiter", want, rsp_payload);
               end
            end
         end
      end
      outstanding <= pending_replies.size();
   end

endmodule

[tb/tb_mailbox_ring_deque.sv]
// testbench top for the mailbox ring deque: clock, reset, stimulus and verdict
module tb_mailbox_ring_deque;
   import mbx_pkg::*;

   localparam logic [KIND_W-1:0] KIND_SPARE      = 2'd3;
   localparam logic [MSG_W-1:0]  ALL_ONES        = '1;
   localparam int unsigned       ITEMS_PER_PHASE = 50;
   localparam int unsigned       HOLD_CYCLES     = 150;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_payload;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [ADDR_W-1:0] paddr       = '0;
   logic [DATA_W-1:0] pwdata      = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   int                failures;
   int                outstanding;
   bit                tx_quiet     = 1'b0;
   bit                rx_quiet     = 1'b0;
   bit                hold_request = 1'b0;
   int unsigned       sent_count   = 0;
   int unsigned       cap_writes   = 0;
   logic [CAP_W-1:0]  phase_caps [8];

   mailbox_ring_deque dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   mailbox_ring_deque_checker mbx_watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic req_type make_req(input logic [KIND_W-1:0] kind,
                                        input logic [MSG_W-1:0] message,
                                        input logic waiter);
      req_type op;
      op.kind           = kind;
      op.message        = message;
      op.waiter_present = waiter;
      return op;
   endfunction

   // fill runs lean on posts, drain runs on gets, so the ring sweeps between empty and full
   function automatic req_type random_request(input bit fill_bias);
      req_type     op;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (fill_bias) begin
         op.kind = (pick < 25) ? KIND_GET : (pick < 60) ? KIND_POST_TAIL :
                   (pick < 90) ? KIND_POST_HEAD : KIND_SPARE;
      end else begin
         op.kind = (pick < 60) ? KIND_GET : (pick < 80) ? KIND_POST_TAIL :
                   (pick < 95) ? KIND_POST_HEAD : KIND_SPARE;
      end
      op.waiter_present = ($urandom_range(0, 6) == 0);
      case ($urandom_range(0, 9))
         0: begin
            op.message = '0;
         end
         1: begin
            op.message = ALL_ONES;
         end
         default: begin
            op.message = $urandom;
         end
      endcase
      return op;
   endfunction

   task automatic send_request(input req_type op);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= op;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] value);
      wait_for_results();
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CAPACITY_IDX, 2'b00};
      pwdata  <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cap_writes++;
   endtask

   // result side: random stalls per beat, plus one long hold-off on request
   initial begin
      int unsigned pause;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         pause = rx_quiet ? 0 : $urandom_range(0, 12);
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      bit          fill_bias;
      int unsigned run_left;
      fill_bias = 1'b0;
      run_left  = 0;
      phase_caps = '{5'd31, 5'd1, 5'd16, 5'd0, 5'd0, 5'd3, 5'd0, 5'd16};
      phase_caps[3] = CAP_W'($urandom_range(1, 16));
      phase_caps[6] = CAP_W'($urandom_range(0, 31));
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset capacity, empty mailbox
      send_request(make_req(KIND_GET, ALL_ONES, 1'b1));
      send_request(make_req(KIND_POST_TAIL, '0, 1'b0));
      send_request(make_req(KIND_POST_TAIL, ALL_ONES, 1'b0));
      send_request(make_req(KIND_POST_HEAD, 32'hA5A5_5A5A, 1'b0));
      send_request(make_req(KIND_SPARE, 32'h1234_5678, 1'b0));
      send_request(make_req(KIND_POST_TAIL, 32'h0F0F_F0F0, 1'b1));
      send_request(make_req(KIND_POST_HEAD, 32'h8000_0001, 1'b1));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b1));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));

      // two slots: full on both ends, waiter while full
      set_capacity(5'd2);
      send_request(make_req(KIND_POST_TAIL, 32'h1111_1111, 1'b0));
      send_request(make_req(KIND_POST_HEAD, 32'h2222_2222, 1'b0));
      send_request(make_req(KIND_POST_TAIL, 32'h3333_3333, 1'b0));
      send_request(make_req(KIND_SPARE, 32'h4444_4444, 1'b0));
      send_request(make_req(KIND_POST_TAIL, ALL_ONES, 1'b1));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_POST_HEAD, 32'h5555_5555, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));

      // zero capacity behaves as one slot
      set_capacity(5'd0);
      send_request(make_req(KIND_POST_TAIL, 32'h6666_6666, 1'b0));
      send_request(make_req(KIND_POST_HEAD, 32'h7777_7777, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));
      send_request(make_req(KIND_GET, '0, 1'b0));

      for (int p = 0; p < 8; p++) begin
         set_capacity(phase_caps[p]);
         if (p == 2) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 25 == 0) begin
               tx_quiet = ($urandom_range(0, 3) == 0);
               rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (p == 5 && n == ITEMS_PER_PHASE / 2) begin
               wait_for_results();
            end
            if (run_left == 0) begin
               fill_bias = ~fill_bias;
               run_left  = $urandom_range(1, 20);
            end
            run_left--;
            send_request(random_request(fill_bias));
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      $write("run covered %0d request beats over %0d capacity writes ",
             sent_count, cap_writes);
      $display("(zero, one, sixteen, thirty-one and random),");
      $display("with random gaps on both channels and one long result hold-off");
      if (failures == 0 && outstanding == 0) begin
         $display("tb_mailbox_ring_deque: PASS");
      end else begin
         $display("tb_mailbox_ring_deque: FAIL");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("tb_mailbox_ring_deque: FAIL");
      $finish;
   end

endmodule

[sim.f]
src/mbx_pkg.sv
src/mbx_slot_ram.sv
src/mailbox_ring_deque.sv
tb/mailbox_ring_deque_checker.sv
tb/tb_mailbox_ring_deque.sv
